@@ rtl/lhq_pkg.sv @@
// Shared types and constants of the latency histogram.
`timescale 1ns / 1ps
package lhq_pkg;

    localparam int NUM_BOUNDS  = 7;
    localparam int IDX_WIDTH   = 3;
    localparam int COUNT_WIDTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SUM_WIDTH   = 64;
    localparam int Q_WIDTH     = 17;
    localparam int Q_FRAC      = 16;
    localparam int TGT_WIDTH   = COUNT_WIDTH + Q_FRAC;
    localparam int OUT_WIDTH   = 32;
    localparam int DIV_STEPS   = SUM_WIDTH;
    localparam int QUEUE_DEPTH = 2;
    localparam int LEVEL_WIDTH = 2;

    localparam logic [VALUE_WIDTH-1:0] BOUND_RESET [NUM_BOUNDS] = '{
        32'd1024, 32'd2048, 32'd5120, 32'd10240, 32'd51200, 32'd102400, 32'd512000
    };
    localparam logic [IDX_WIDTH-1:0] ACTIVE_RESET = 3'd7;
    localparam logic [IDX_WIDTH-1:0] REG_ACTIVE   = 3'd7;

    typedef enum logic [2:0] {
        OP_OBSERVE  = 3'd0,
        OP_CLEAR    = 3'd1,
        OP_SNAPSHOT = 3'd2,
        OP_MEAN     = 3'd3,
        OP_QUANTILE = 3'd4
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [VALUE_WIDTH-1:0] value;
        logic [Q_WIDTH-1:0]     frac;
    } req_t;

    typedef struct packed {
        logic                   valid;
        logic [LEVEL_WIDTH-1:0] level;
    } queue_stat_t;

endpackage

@@ rtl/lhq_front.sv @@
// Front end: accepts requests, drops unknown operations and queues the rest.
`timescale 1ns / 1ps
module lhq_front
    import lhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample_value, quantile_fraction, zero fill
    input  logic [2:0]  s_tuser,   // operation
    input  logic        pop,
    output req_t        req,
    output queue_stat_t stat
);

    req_t                   slot_reg [QUEUE_DEPTH];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_WIDTH-1:0] level_reg, level_next;
    logic                   push;
    logic                   do_pop;
    logic                   known;
    req_t                   incoming;

    assign s_tready = (level_reg != LEVEL_WIDTH'(QUEUE_DEPTH));
    assign known    = (s_tuser <= OP_QUANTILE);
    assign push     = s_tvalid && s_tready && known;
    assign do_pop   = pop && (level_reg != '0);

    always_comb
    begin
        incoming.op    = op_t'(s_tuser);
        incoming.value = s_tdata[VALUE_WIDTH-1:0];
        incoming.frac  = s_tdata[VALUE_WIDTH+Q_WIDTH-1:VALUE_WIDTH];
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next     = level_reg + LEVEL_WIDTH'(push) - LEVEL_WIDTH'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign req        = slot_reg[rd_ptr_reg];
    assign stat.valid = (level_reg != '0);
    assign stat.level = level_reg;

endmodule

@@ rtl/lhq_back.sv @@
// Back end: histogram state, bucket scan, shared divider and result register.
`timescale 1ns / 1ps
module lhq_back
    import lhq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    input  req_t           req,
    input  queue_stat_t    stat,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [191:0]   m_tdata,  // bound, total, observed, sum, estimate
    output logic [0:0]     m_tuser,  // bucket_is_inf
    output logic           m_tlast
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SNAP  = 9'b000000010,
        ST_QMUL  = 9'b000000100,
        ST_QSCAN = 9'b000001000,
        ST_QPL   = 9'b000010000,
        ST_QPH   = 9'b000100000,
        ST_QSUM  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    state_t                  state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  bound_reg [NUM_BOUNDS];
    logic [IDX_WIDTH-1:0]    active_reg;
    logic [COUNT_WIDTH-1:0]  count_reg [NUM_BOUNDS];
    logic [COUNT_WIDTH-1:0]  obs_reg;
    logic [SUM_WIDTH-1:0]    sum_reg;
    logic [IDX_WIDTH-1:0]    idx_reg;
    logic [COUNT_WIDTH-1:0]  prev_c_reg;
    logic [VALUE_WIDTH-1:0]  prev_b_reg;
    logic                    miss_reg;
    logic                    mean_reg;
    logic [Q_FRAC-1:0]       frac_reg;
    logic [TGT_WIDTH-1:0]    target_reg;
    logic [VALUE_WIDTH-1:0]  lower_reg;
    logic [VALUE_WIDTH-1:0]  span_reg;
    logic [TGT_WIDTH-1:0]    num_reg;
    logic [COUNT_WIDTH-1:0]  den_reg;
    logic [63:0]             prodl_reg;
    logic [TGT_WIDTH-1:0]    prodh_reg;
    logic [SUM_WIDTH-1:0]    dvd_reg;
    logic [COUNT_WIDTH-1:0]  rem_reg;
    logic [5:0]              cnt_reg;
    logic [OUT_WIDTH-1:0]    est_reg;

    logic                    o_valid_reg;
    logic [OUT_WIDTH-1:0]    o_bound_reg, o_total_reg, o_obs_reg, o_est_reg;
    logic [SUM_WIDTH-1:0]    o_sum_reg;
    logic                    o_inf_reg, o_last_reg;

    logic [IDX_WIDTH-1:0]    n_used;
    logic                    load_ok;
    logic [COUNT_WIDTH-1:0]  c_sel;
    logic [VALUE_WIDTH-1:0]  b_sel;
    logic                    at_end;
    logic                    hit;
    logic [TGT_WIDTH-1:0]    lc_shift;
    logic [VALUE_WIDTH:0]    mid_sum;
    logic [SUM_WIDTH:0]      sum_add;
    logic [COUNT_WIDTH:0]    rem_shift;
    logic                    rem_ge;
    logic [SUM_WIDTH-1:0]    quot_next;
    logic [79:0]             prod_sum;

    assign cfg_ready = 1'b1;
    assign n_used    = (active_reg > IDX_WIDTH'(NUM_BOUNDS)) ? IDX_WIDTH'(NUM_BOUNDS)
                                                             : active_reg;
    assign load_ok   = !o_valid_reg || m_tready;
    assign at_end    = (idx_reg >= n_used);
    assign c_sel     = at_end ? '0 : count_reg[idx_reg];
    assign b_sel     = at_end ? '0 : bound_reg[idx_reg];
    assign hit       = !miss_reg && (c_sel != '0) && ({c_sel, 16'b0} >= target_reg);
    assign lc_shift  = {prev_c_reg, 16'b0};
    assign mid_sum   = {1'b0, prev_b_reg} + {1'b0, b_sel};
    assign sum_add   = {1'b0, sum_reg} + (SUM_WIDTH+1)'(req.value);
    assign rem_shift = {rem_reg, dvd_reg[SUM_WIDTH-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign quot_next = {dvd_reg[SUM_WIDTH-2:0], rem_ge};
    assign prod_sum  = {16'b0, prodl_reg} + {prodh_reg, 32'b0};
    assign pop       = (state_reg == ST_IDLE) && stat.valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.valid)
                begin
                    case (req.op)
                        OP_SNAPSHOT: state_next = ST_SNAP;
                        OP_MEAN:     state_next = (obs_reg == '0) ? ST_EMIT : ST_DIV;
                        OP_QUANTILE:
                        begin
                            if (obs_reg == '0 || req.frac == '0)
                            begin
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_QMUL;
                            end
                        end
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SNAP:  if (load_ok && at_end) state_next = ST_IDLE;
            ST_QMUL:  state_next = ST_QSCAN;
            ST_QSCAN:
            begin
                if (at_end || (hit && c_sel <= prev_c_reg))
                begin
                    state_next = ST_EMIT;
                end
                else if (hit)
                begin
                    state_next = ST_QPL;
                end
            end
            ST_QPL:   state_next = ST_QPH;
            ST_QPH:   state_next = ST_QSUM;
            ST_QSUM:  state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == '0) state_next = ST_EMIT;
            ST_EMIT:  if (load_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= ACTIVE_RESET;
            obs_reg     <= '0;
            sum_reg     <= '0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bound_reg[i] <= BOUND_RESET[i];
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_ACTIVE)
                begin
                    active_reg <= cfg_data[IDX_WIDTH-1:0];
                end
                else
                begin
                    bound_reg[cfg_index] <= cfg_data;
                end
            end
            if (state_reg == ST_IDLE && stat.valid && req.op == OP_OBSERVE)
            begin
                for (int i = 0; i < NUM_BOUNDS; i++)
                begin
                    if (IDX_WIDTH'(i) < n_used && bound_reg[i] >= req.value
                        && count_reg[i] != COUNT_MAX)
                    begin
                        count_reg[i] <= count_reg[i] + 1'b1;
                    end
                end
                if (obs_reg != COUNT_MAX)
                begin
                    obs_reg <= obs_reg + 1'b1;
                end
                sum_reg <= sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
            end
            if (state_reg == ST_IDLE && stat.valid && req.op == OP_CLEAR)
            begin
                obs_reg <= '0;
                sum_reg <= '0;
                for (int i = 0; i < NUM_BOUNDS; i++)
                begin
                    count_reg[i] <= '0;
                end
            end
            if ((state_reg == ST_SNAP || state_reg == ST_EMIT) && load_ok)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg    <= '0;
                prev_c_reg <= '0;
                prev_b_reg <= '0;
                est_reg    <= '0;
                mean_reg   <= (req.op == OP_MEAN);
                miss_reg   <= (req.frac[Q_FRAC] == 1'b1);
                frac_reg   <= req.frac[Q_FRAC-1:0];
                dvd_reg    <= sum_reg;
                den_reg    <= obs_reg;
                rem_reg    <= '0;
                cnt_reg    <= 6'(DIV_STEPS - 1);
            end
            ST_SNAP:
            begin
                if (load_ok)
                begin
                    idx_reg     <= idx_reg + 1'b1;
                    o_bound_reg <= b_sel;
                    o_total_reg <= at_end ? obs_reg[OUT_WIDTH-1:0] : c_sel[OUT_WIDTH-1:0];
                    o_inf_reg   <= at_end;
                    o_last_reg  <= at_end;
                    o_est_reg   <= '0;
                    o_obs_reg   <= obs_reg[OUT_WIDTH-1:0];
                    o_sum_reg   <= sum_reg;
                end
            end
            ST_QMUL:
            begin
                target_reg <= obs_reg * frac_reg;
            end
            ST_QSCAN:
            begin
                if (at_end)
                begin
                    est_reg <= prev_b_reg;
                end
                else if (hit)
                begin
                    est_reg   <= mid_sum[VALUE_WIDTH:1];
                    lower_reg <= prev_b_reg;
                    span_reg  <= (b_sel > prev_b_reg) ? b_sel - prev_b_reg : '0;
                    num_reg   <= (lc_shift >= target_reg) ? '0 : target_reg - lc_shift;
                    den_reg   <= c_sel - prev_c_reg;
                end
                else
                begin
                    idx_reg    <= idx_reg + 1'b1;
                    prev_c_reg <= c_sel;
                    prev_b_reg <= b_sel;
                end
            end
            ST_QPL:
            begin
                prodl_reg <= num_reg[31:0] * span_reg;
            end
            ST_QPH:
            begin
                prodh_reg <= num_reg[TGT_WIDTH-1:32] * span_reg;
            end
            ST_QSUM:
            begin
                dvd_reg <= prod_sum[79:16];
                rem_reg <= '0;
                cnt_reg <= 6'(DIV_STEPS - 1);
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? COUNT_WIDTH'(rem_shift - {1'b0, den_reg})
                                  : rem_shift[COUNT_WIDTH-1:0];
                dvd_reg <= quot_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (mean_reg)
                    begin
                        est_reg <= (quot_next[SUM_WIDTH-1:OUT_WIDTH] != '0) ? '1
                                   : quot_next[OUT_WIDTH-1:0];
                    end
                    else
                    begin
                        est_reg <= lower_reg + quot_next[OUT_WIDTH-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    o_bound_reg <= '0;
                    o_total_reg <= '0;
                    o_inf_reg   <= 1'b0;
                    o_last_reg  <= 1'b1;
                    o_est_reg   <= est_reg;
                    o_obs_reg   <= obs_reg[OUT_WIDTH-1:0];
                    o_sum_reg   <= sum_reg;
                end
            end
            default:
            begin
                idx_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_est_reg, o_sum_reg, o_obs_reg, o_total_reg, o_bound_reg};
    assign m_tuser  = o_inf_reg;
    assign m_tlast  = o_last_reg;

endmodule

@@ rtl/latency_histogram_with_quantile.sv @@
// Top level of the cumulative latency histogram with mean and quantile estimates.
`timescale 1ns / 1ps
// Requests enter on the s_ stream with the operation in s_tuser and are queued two deep,
// so the requester is held up only once two requests wait behind a busy back end. An
// observe or a clear is handled in the idle state, and observes can follow each other in
// every cycle. A snapshot gives one result per active bucket and then the +Inf entry, one
// a cycle as the output is taken. A mean runs the one-bit-a-cycle 64-bit divider; a
// quantile forms the target, scans the buckets, forms the product from two partial
// products and their sum and makes the same divider pass. Bounds and the active bucket
// count are written on the cfg port, which is always ready, and should only change while
// the block is idle.
module latency_histogram_with_quantile
    import lhq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // sample_value, quantile_fraction, zero fill
    input  logic [2:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // bucket_bound, bucket_total, total_observed,
                                    // total_sum, estimate
    output logic [0:0]   m_tuser,   // bucket_is_inf
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    req_t        req;
    queue_stat_t stat;
    logic        pop;

    lhq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .req      (req),
        .stat     (stat)
    );

    lhq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .stat      (stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // The +Inf entry always closes a snapshot.
    a_inf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("inf entry without last");

    // The +Inf entry carries no bound.
    a_inf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == '0)
        else $error("inf entry with bound");

    // A last result that is not the +Inf entry is a mean or quantile with no bucket data.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0] || m_tdata[63:0] == '0)
        else $error("estimate carries bucket data");

    // The queue never holds more than its depth.
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        stat.level <= LEVEL_WIDTH'(QUEUE_DEPTH))
        else $error("queue overflow");
`endif

endmodule

@@ bench/tb_latency_histogram_with_quantile.sv @@
// Self-checking testbench of the cumulative latency histogram with mean and quantile estimates.
`timescale 1ns / 1ps
module tb_latency_histogram_with_quantile;
    import lhq_pkg::*;

    localparam logic [2:0] REG_BOUND_A     = 3'd0;
    localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI  = 3'd7;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam int         SETTLE_CYCLES   = 100;
    localparam int         HOLD_CYCLES     = 400;
    localparam logic [31:0] ALL_ONES32     = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL_ONES64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [16:0] Q_ONE          = 17'd65536;

    typedef struct {
        logic [31:0] bound;
        logic [31:0] total;
        logic        is_inf;
        logic [31:0] observed;
        logic [63:0] sum;
        logic [31:0] estimate;
        logic        last;
    } histo_result_t;

    class histogram_scoreboard;
        logic [31:0]   bounds [NUM_BOUNDS];
        logic [2:0]    active;
        logic [31:0]   counts [NUM_BOUNDS];
        logic [31:0]   observed;
        logic [63:0]   sum;
        histo_result_t pending_results [$];
        int            mismatches;

        function new();
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bounds[i] = BOUND_RESET[i];
                counts[i] = '0;
            end
            active     = ACTIVE_RESET;
            observed   = '0;
            sum        = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [31:0] data);
            if (index == REG_ACTIVE)
                active = data[2:0];
            else
                bounds[index] = data;
        endfunction

        function logic [31:0] last_bound();
            return (active == 0) ? 32'd0 : bounds[active - 1];
        endfunction

        function logic [31:0] quantile_estimate(logic [16:0] q);
            logic [127:0] target, scaled, base, num, prod, den, quo;
            logic [31:0]  c, lc, lower, upper, span;
            if (observed == 0 || q == 0)
                return 32'd0;
            if (q >= Q_ONE)
                return last_bound();
            target = 128'(observed) * 128'(q);
            for (int i = 0; i < active; i++)
            begin
                c      = counts[i];
                scaled = 128'(c) << 16;
                if (c == 0 || scaled < target)
                    continue;
                lower = (i == 0) ? 32'd0 : bounds[i - 1];
                upper = bounds[i];
                lc    = (i == 0) ? 32'd0 : counts[i - 1];
                if (c <= lc)
                    return 32'((33'(lower) + 33'(upper)) >> 1);
                span = (upper > lower) ? upper - lower : 32'd0;
                base = 128'(lc) << 16;
                num  = (base >= target) ? 128'd0 : target - base;
                prod = num * 128'(span);
                den  = 128'(c - lc) << 16;
                quo  = prod / den;
                return lower + quo[31:0];
            end
            return last_bound();
        endfunction

        function void push(logic [31:0] bound, logic [31:0] total, logic is_inf,
                           logic [31:0] estimate, logic last);
            histo_result_t r;
            r.bound    = bound;
            r.total    = total;
            r.is_inf   = is_inf;
            r.observed = observed;
            r.sum      = sum;
            r.estimate = estimate;
            r.last     = last;
            pending_results = {pending_results, r};
        endfunction

        function void note_request(logic [2:0] op, logic [31:0] value, logic [16:0] q);
            logic [64:0] wide_sum;
            logic [63:0] mean;
            case (op)
                OP_OBSERVE:
                begin
                    for (int i = 0; i < active; i++)
                        if (bounds[i] >= value && counts[i] != ALL_ONES32)
                            counts[i]++;
                    if (observed != ALL_ONES32)
                        observed++;
                    wide_sum = 65'(sum) + 65'(value);
                    sum = wide_sum[64] ? ALL_ONES64 : wide_sum[63:0];
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < NUM_BOUNDS; i++)
                        counts[i] = '0;
                    observed = '0;
                    sum      = '0;
                end
                OP_SNAPSHOT:
                begin
                    for (int i = 0; i < active; i++)
                        push(bounds[i], counts[i], 1'b0, 32'd0, 1'b0);
                    push(32'd0, observed, 1'b1, 32'd0, 1'b1);
                end
                OP_MEAN:
                begin
                    mean = (observed == 0) ? 64'd0 : sum / 64'(observed);
                    push(32'd0, 32'd0, 1'b0, (mean > 64'(ALL_ONES32)) ? ALL_ONES32 : mean[31:0],
                         1'b1);
                end
                OP_QUANTILE:
                    push(32'd0, 32'd0, 1'b0, quantile_estimate(q), 1'b1);
                default:
                    ;
            endcase
        endfunction

        function void check_result(histo_result_t got);
            histo_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: bound %h total %h estimate %h",
                             got.bound, got.total, got.estimate);
                return;
            end
            want = pending_results.pop_front();
            if (got.bound !== want.bound || got.total !== want.total
                || got.is_inf !== want.is_inf || got.observed !== want.observed
                || got.sum !== want.sum || got.estimate !== want.estimate
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch: expected bound %h total %h inf %b count %h sum %h est %h last %b",
                             want.bound, want.total, want.is_inf, want.observed, want.sum,
                             want.estimate, want.last);
                    $display("          actual   bound %h total %h inf %b count %h sum %h est %h last %b",
                             got.bound, got.total, got.is_inf, got.observed, got.sum,
                             got.estimate, got.last);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    histogram_scoreboard histo = new();
    bit  gaps_on;
    bit  hold_request;
    bit  hold_taken;
    int  hold_off_cycles;
    int  cycle_count = 0;

    latency_histogram_with_quantile DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready        <= 1'b0;
            hold_taken      <= 1'b0;
            hold_off_cycles <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                histo.check_result('{m_tdata[31:0], m_tdata[63:32], m_tuser[0],
                                     m_tdata[95:64], m_tdata[159:96], m_tdata[191:160],
                                     m_tlast});
            if (hold_request && !hold_taken)
            begin
                hold_taken      <= 1'b1;
                hold_off_cycles <= HOLD_CYCLES;
                m_tready        <= 1'b0;
            end
            else if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !gaps_on || ($urandom_range(0, 99) < 75);
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [31:0] value, logic [16:0] q);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, q, value};
        do
            @(posedge clk);
        while (!s_tready);
        histo.note_request(op, value, q);
    endtask

    task automatic write_register(logic [2:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        histo.write_register(index, data);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (histo.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bounds(logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                                logic [31:0] b3, logic [31:0] b4, logic [31:0] b5,
                                logic [31:0] b6, logic [2:0] in_use);
        logic [31:0] b [NUM_BOUNDS];
        b = '{b0, b1, b2, b3, b4, b5, b6};
        for (int i = 0; i < NUM_BOUNDS; i++)
            write_register(REG_BOUND_A + 3'(i), b[i]);
        write_register(REG_ACTIVE, in_use);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int count);
        int          roll;
        logic [2:0]  op;
        logic [31:0] value;
        logic [16:0] q;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                gaps_on = $urandom_range(0, 3) != 0;
            roll = $urandom_range(0, 99);
            if (roll < 58)
                op = OP_OBSERVE;
            else if (roll < 68)
                op = OP_SNAPSHOT;
            else if (roll < 76)
                op = OP_MEAN;
            else if (roll < 93)
                op = OP_QUANTILE;
            else if (roll < 96)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            roll = $urandom_range(0, 9);
            if (roll < 5)
                value = histo.bounds[$urandom_range(0, NUM_BOUNDS - 1)]
                        + 32'($urandom_range(0, 2)) - 32'd1;
            else if (roll < 8)
                value = $urandom_range(0, 600000);
            else
                value = $urandom;
            roll = $urandom_range(0, 9);
            if (roll < 7)
                q = 17'($urandom_range(1, 65535));
            else if (roll < 8)
                q = 17'($urandom);
            else
                q = (roll == 8) ? 17'd0 : Q_ONE;
            send_request(op, value, q);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = OP_OBSERVE;
        cfg_valid       = 1'b0;
        cfg_index       = REG_BOUND_A;
        cfg_data        = '0;
        gaps_on         = 1'b1;
        hold_request    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_MEAN, 32'd0, 17'd0);
        send_request(OP_QUANTILE, 32'd0, 17'd32768);
        send_request(OP_OBSERVE, 32'd0, 17'd0);
        send_request(OP_OBSERVE, 32'd1024, 17'd0);
        send_request(OP_OBSERVE, 32'd1025, 17'd0);
        send_request(OP_OBSERVE, 32'd512000, 17'd0);
        send_request(OP_OBSERVE, ALL_ONES32, 17'd0);
        send_request(OP_SNAPSHOT, 32'd0, 17'd0);
        send_request(OP_MEAN, 32'd0, 17'd0);
        send_request(OP_QUANTILE, 32'd0, 17'd0);
        send_request(OP_QUANTILE, 32'd0, 17'd1);
        send_request(OP_QUANTILE, 32'd0, 17'd32768);
        send_request(OP_QUANTILE, 32'd0, 17'd65535);
        send_request(OP_QUANTILE, 32'd0, Q_ONE);
        send_request(OP_QUANTILE, 32'd0, 17'h1FFFF);
        send_request(OP_RESERVED_LO, ALL_ONES32, 17'h1FFFF);
        send_request(OP_RESERVED_HI, 32'd0, 17'd0);
        send_request(OP_CLEAR, 32'd0, 17'd0);
        send_request(OP_SNAPSHOT, 32'd0, 17'd0);
        for (int i = 0; i < 4; i++)
            send_request(OP_OBSERVE, ALL_ONES32, 17'd0);
        send_request(OP_MEAN, 32'd0, 17'd0);

        hold_request = 1'b1;
        random_requests(120);
        settle();

        write_bounds(32'd0, 32'd1, 32'd100, 32'd5000, 32'd70000, 32'h7FFF_FFFF, ALL_ONES32,
                     3'd7);
        send_request(OP_CLEAR, 32'd0, 17'd0);
        random_requests(70);
        settle();

        write_bounds(32'd10, 32'd20, 32'd30, 32'd40, 32'd50, 32'd60, 32'd70, 3'd0);
        random_requests(40);
        settle();

        write_bounds(32'd900000, 32'd4000, 32'd4000, 32'd200, 32'd800000, 32'd10, 32'd600,
                     3'd7);
        random_requests(70);
        settle();

        write_bounds(ALL_ONES32, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd1);
        random_requests(30);
        settle();

        if (histo.mismatches == 0 && histo.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
